// ----- src/trrt_pkg.sv -----
// Shared types and codes for the threshold relay rule table.
`default_nettype none

package trrt_pkg;

  localparam int SLOT_W = 2;
  localparam int KIND_W = 2;
  localparam int RELAY_W = 3;
  localparam int FIELD_W = 16;
  localparam int RELAY_OUT_W = 8;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY = 2'd0,
    KIND_LESS = 2'd1,
    KIND_GREATER = 2'd2,
    KIND_INERT = 2'd3
  } rule_kind_t;

  typedef struct packed {
    logic operation;
    logic [SLOT_W-1:0] sensor_slot;
    logic [KIND_W-1:0] rule_kind;
    logic signed [FIELD_W-1:0] threshold;
    logic [RELAY_W-1:0] relay_select;
    logic signed [FIELD_W-1:0] reading;
  } in_item_t;

  typedef struct packed {
    logic [RELAY_OUT_W-1:0] relay_states;
    logic rule_dropped;
  } out_item_t;

  typedef struct packed {
    logic op;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic [RELAY_W-1:0] relay;
    logic placed;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/trrt_cell.sv -----
// One column of rule cells: clears, places and evaluates rules as a beat passes through.
`default_nettype none

module trrt_cell #(
  parameter int NUM_PARAMS = 4,
  parameter int NUM_RELAYS = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  trrt_pkg::cell_ctrl_t          in_ctrl,
  input  logic signed [VALUE_BITS-1:0]  in_operand,
  input  logic [NUM_RELAYS-1:0]         in_levels,
  input  logic                          hold,
  output logic                          out_valid,
  output trrt_pkg::cell_ctrl_t          out_ctrl,
  output logic signed [VALUE_BITS-1:0]  out_operand,
  output logic [NUM_RELAYS-1:0]         out_levels
);
  import trrt_pkg::*;

  localparam int ROW_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  logic [KIND_W-1:0]            kind_col [NUM_PARAMS];
  logic signed [VALUE_BITS-1:0] bound_col [NUM_PARAMS];
  logic [RELAY_W-1:0]           relay_col [NUM_PARAMS];

  logic [KIND_W-1:0]            kind_next [NUM_PARAMS];
  logic signed [VALUE_BITS-1:0] bound_next [NUM_PARAMS];
  logic [RELAY_W-1:0]           relay_next [NUM_PARAMS];
  logic                         placed_next;
  logic [NUM_RELAYS-1:0]        levels_next;

  logic [ROW_W-1:0]             row;
  logic                         row_ok;
  logic [KIND_W-1:0]            sel_kind;
  logic                         drive;
  logic                         hit;

  assign row = ROW_W'(in_ctrl.slot);
  assign row_ok = 32'(in_ctrl.slot) < 32'(NUM_PARAMS);

  always_comb begin
    kind_next = kind_col;
    bound_next = bound_col;
    relay_next = relay_col;
    placed_next = in_ctrl.placed;
    levels_next = in_levels;
    sel_kind = KIND_EMPTY;
    drive = 1'b0;
    hit = 1'b0;
    if (in_ctrl.op == OP_STORE) begin
      for (int i = 0; i < NUM_PARAMS; i++) begin
        if (relay_col[i] == in_ctrl.relay) begin
          kind_next[i] = KIND_EMPTY;
        end
      end
      if (row_ok && !in_ctrl.placed && kind_next[row] == KIND_EMPTY) begin
        kind_next[row] = in_ctrl.kind;
        bound_next[row] = in_operand;
        relay_next[row] = in_ctrl.relay;
        placed_next = 1'b1;
      end
    end else if (row_ok) begin
      sel_kind = kind_col[row];
      case (sel_kind)
        KIND_LESS: begin
          drive = 1'b1;
          hit = in_operand < bound_col[row];
        end
        KIND_GREATER: begin
          drive = 1'b1;
          hit = in_operand > bound_col[row];
        end
        default: begin
          drive = 1'b0;
          hit = 1'b0;
        end
      endcase
      for (int r = 0; r < NUM_RELAYS; r++) begin
        if (drive && 32'(relay_col[row]) == 32'(r)) begin
          levels_next[r] = hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PARAMS; i++) begin
        kind_col[i] <= KIND_EMPTY;
        bound_col[i] <= '0;
        relay_col[i] <= '0;
      end
    end else if (in_valid) begin
      kind_col <= kind_next;
      bound_col <= bound_next;
      relay_col <= relay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid || (out_valid && hold);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_ctrl <= '{op: in_ctrl.op, slot: in_ctrl.slot, kind: in_ctrl.kind,
                    relay: in_ctrl.relay, placed: placed_next};
      out_operand <= in_operand;
      out_levels <= levels_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/threshold_relay_rule_table_core.sv -----
// Top level of the threshold relay rule table: a chain of rule columns and the result register.
//
// Input beats carry either a rule to store or a sensor reading to apply; every beat
// returns one result beat with the relay levels and a flag set when a stored rule found
// no free cell in its sensor row. A beat enters the first column at acceptance and moves
// one column per cycle; each column clears rules that drive the same relay, places the
// rule in the first free cell of the row, or evaluates that row's rule against the
// reading. The result moves from the last column into the output register. One beat is
// in the chain at a time, so the block takes no new beat until the last one has left
// the chain. in_ready rises again as soon as the result has moved into the output
// register, so the next beat can enter while that result still waits. If the receiver
// stalls with a result pending, the following beat waits at the end of the chain and
// holds in_ready low. Reset empties every rule cell, turns all relays off and drops any
// beat in flight.
`default_nettype none

module threshold_relay_rule_table_core #(
  parameter int NUM_PARAMS = 4,
  parameter int NUM_RELAYS = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  trrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output trrt_pkg::out_item_t out_data
);
  import trrt_pkg::*;

  localparam int EXT_W = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int LVL_W = (NUM_RELAYS > RELAY_OUT_W) ? NUM_RELAYS : RELAY_OUT_W;
  localparam int LAST = NUM_RELAYS - 1;

  logic [NUM_RELAYS-1:0]        relay_levels;
  logic [NUM_RELAYS-1:0]        cell_valid;
  cell_ctrl_t                   cell_ctrl [NUM_RELAYS];
  logic signed [VALUE_BITS-1:0] cell_operand [NUM_RELAYS];
  logic [NUM_RELAYS-1:0]        cell_levels [NUM_RELAYS];

  logic                         accept;
  logic [FIELD_W-1:0]           raw_value;
  logic [EXT_W-1:0]             raw_ext;
  logic signed [VALUE_BITS-1:0] entry_operand;
  cell_ctrl_t                   entry_ctrl;
  logic                         xfer;
  logic                         stall;
  logic [LVL_W-1:0]             levels_ext;

  assign in_ready = !(|cell_valid);
  assign accept = in_valid && in_ready;

  assign raw_value = (in_data.operation == OP_STORE) ? in_data.threshold : in_data.reading;
  assign raw_ext = EXT_W'(raw_value);
  assign entry_operand = signed'(raw_ext[VALUE_BITS-1:0]);
  assign entry_ctrl = '{op: in_data.operation, slot: in_data.sensor_slot,
                        kind: in_data.rule_kind, relay: in_data.relay_select,
                        placed: 1'b0};

  assign xfer = cell_valid[LAST] && (!out_valid || out_ready);
  assign stall = out_valid && !out_ready;

  for (genvar j = 0; j < NUM_RELAYS; j++) begin : g_col
    if (j == 0) begin : g_first
      trrt_cell #(
        .NUM_PARAMS(NUM_PARAMS),
        .NUM_RELAYS(NUM_RELAYS),
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .in_valid(accept),
        .in_ctrl(entry_ctrl),
        .in_operand(entry_operand),
        .in_levels(relay_levels),
        .hold((LAST == 0) ? stall : 1'b0),
        .out_valid(cell_valid[j]),
        .out_ctrl(cell_ctrl[j]),
        .out_operand(cell_operand[j]),
        .out_levels(cell_levels[j])
      );
    end else begin : g_next
      trrt_cell #(
        .NUM_PARAMS(NUM_PARAMS),
        .NUM_RELAYS(NUM_RELAYS),
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .in_valid(cell_valid[j-1]),
        .in_ctrl(cell_ctrl[j-1]),
        .in_operand(cell_operand[j-1]),
        .in_levels(cell_levels[j-1]),
        .hold((j == LAST) ? stall : 1'b0),
        .out_valid(cell_valid[j]),
        .out_ctrl(cell_ctrl[j]),
        .out_operand(cell_operand[j]),
        .out_levels(cell_levels[j])
      );
    end
  end

  assign levels_ext = LVL_W'(cell_levels[LAST]);

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_levels <= '0;
      out_valid <= 1'b0;
    end else begin
      if (xfer) begin
        relay_levels <= cell_levels[LAST];
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_data.relay_states <= levels_ext[RELAY_OUT_W-1:0];
      out_data.rule_dropped <= (cell_ctrl[LAST].op == OP_STORE) && !cell_ctrl[LAST].placed;
    end
  end

`ifndef SYNTHESIS
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid))
    else $error("more than one beat in the column chain");

  a_chain_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##NUM_RELAYS cell_valid[LAST])
    else $error("beat did not reach the last column on time");

  a_levels_hold: assert property (@(posedge clk) disable iff (rst)
    !xfer |=> $stable(relay_levels))
    else $error("relay levels changed without a finished beat");

  a_apply_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (xfer && cell_ctrl[LAST].op == OP_APPLY) |=> !out_data.rule_dropped)
    else $error("apply beat reported a dropped rule");
`endif

endmodule

`default_nettype wire
